[hw/rtl/max_subset_sum_under_limit_defines.svh]
// assertion macros for the subset sum block
`ifndef MAX_SUBSET_SUM_UNDER_LIMIT_DEFINES_SVH
`define MAX_SUBSET_SUM_UNDER_LIMIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/mss_pkg.sv]
// shared types and constants for the subset sum block
`default_nettype none
package mss_pkg;
    localparam int MAX_ITEMS_DEF   = 32;
    localparam int HALF_DEPTH_DEF  = 65536;
    localparam int VAL_W   = 31;
    localparam int SUM_W   = 36;
    localparam int BEST_W  = 37;
    localparam int CNT_W   = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_GEN_RD,
        ST_GEN_MERGE,
        ST_GEN_COPY,
        ST_SRCH_A,
        ST_SRCH_B,
        ST_SRCH_CMP,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

[hw/rtl/mss_sum_ram.sv]
// synchronous sum table with one write port and one registered read port
`default_nettype none
module mss_sum_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic [mss_pkg::SUM_W-1:0] i_wdata,
    input  wire logic [AW-1:0]            i_raddr,
    output logic      [mss_pkg::SUM_W-1:0] o_rdata
);
    import mss_pkg::*;
    logic [SUM_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/max_subset_sum_under_limit.sv]
// top level: item load, subset sum listing by merge, binary search pairing
//
// usage
//   one word per start pulse: i_item_value, i_is_last, taken when i_start is
//   high and o_busy is low. items load at one per cycle while o_busy is low.
//   a word with i_is_last set starts the search; o_busy stays high until the
//   result word is shown on o_best_sum / o_overflowed with o_done for one
//   cycle. the receiver cannot stall, the result is given once.
//   i_cfg_we with i_cfg_data writes sum_limit; write only while idle.
// listing and search
//   listing a half seeds the table with {0}, then folds in one item at a
//   time: each merged entry takes two reads, x and then y, and each
//   copied entry one buffer read and one table write, over 2*len entries.
//   the search reads, for each first-half entry up to the limit, that entry,
//   then makes ceil(log2(len_b)) binary search probes in the second-half
//   table and a final fetch of the settled entry, before the done state.
// reset
//   synchronous, active low: item count, overflow flag, limit and the
//   sequencer clear; the sum memories hold no reset and are always written
//   before they are read.
`default_nettype none
module max_subset_sum_under_limit #(
    parameter int MAX_ITEMS  = mss_pkg::MAX_ITEMS_DEF,
    parameter int HALF_DEPTH = mss_pkg::HALF_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic [mss_pkg::VAL_W-1:0]    i_item_value,
    input  wire logic                         i_is_last,
    input  wire logic                         i_cfg_we,
    input  wire logic [mss_pkg::SUM_W-1:0]    i_cfg_data,
    output logic                              o_done,
    output logic [mss_pkg::BEST_W-1:0]        o_best_sum,
    output logic                              o_overflowed
);
    import mss_pkg::*;
    `include "max_subset_sum_under_limit_defines.svh"

    localparam int AW  = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int LW  = AW + 1;   // table length, can equal depth

    // item store, small register array read at one address
    logic [VAL_W-1:0] r_items [MAX_ITEMS];
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [SUM_W-1:0] r_limit;

    t_state r_state, n_state;

    // generation control
    logic             r_half, n_half;       // 0: first half table, 1: second
    logic [CNT_W-1:0] r_k, n_k;             // items left to fold in
    logic [IW-1:0]    r_iidx, n_iidx;       // item index
    logic [LW-1:0]    r_len, n_len;
    logic [LW-1:0]    r_x, n_x, r_y, n_y, r_o, n_o;
    logic [1:0]       r_ph, n_ph;           // access phase
    logic [SUM_W-1:0] r_tx, n_tx, r_ty, n_ty;
    logic [SUM_W-1:0] r_v, n_v;
    logic [LW-1:0]    r_na_len, n_na_len;   // first-half table length
    logic [CNT_W-1:0] r_na, n_na;

    // search control
    logic [LW-1:0]    r_i, n_i;
    logic [LW-1:0]    r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [SUM_W-1:0] r_s, n_s;
    logic [BEST_W-1:0] r_best, n_best;

    // memories: table a, and table b with the merge buffer in its upper half
    logic             we_a, we_b, we_m;
    logic [AW-1:0]    wa_a, wa_b, wa_m, ra_a, ra_b, ra_m;
    logic [SUM_W-1:0] wd_a, wd_b, wd_m, rd_a, rd_b, rd_m;
    logic             we_p;
    logic [AW:0]      wa_p, ra_p;
    logic [SUM_W-1:0] wd_p, rd_p;

    mss_sum_ram #(.DEPTH(HALF_DEPTH), .AW(AW)) u_ram_a (
        .i_clk(i_clk), .i_we(we_a), .i_waddr(wa_a), .i_wdata(wd_a),
        .i_raddr(ra_a), .o_rdata(rd_a));
    mss_sum_ram #(.DEPTH(2 * HALF_DEPTH), .AW(AW + 1)) u_ram_b (
        .i_clk(i_clk), .i_we(we_p), .i_waddr(wa_p), .i_wdata(wd_p),
        .i_raddr(ra_p), .o_rdata(rd_p));

    // table b and the buffer never write or read in the same cycle
    assign we_p = we_b | we_m;
    assign wa_p = we_m ? {1'b1, wa_m} : {1'b0, wa_b};
    assign wd_p = we_m ? wd_m : wd_b;
    assign ra_p = (r_state == ST_GEN_COPY) ? {1'b1, ra_m} : {1'b0, ra_b};
    assign rd_b = rd_p;
    assign rd_m = rd_p;

    // capacity check for count c
    function automatic logic fits(input logic [CNT_W:0] c);
        logic [CNT_W:0] big;
        big = c - (c >> 1);
        fits = (int'(c) <= MAX_ITEMS) && ((64'd1 << big) <= 64'(HALF_DEPTH));
    endfunction

    logic accept;
    assign accept = i_start && !o_busy;

    // active table read data follows the half being listed
    logic [SUM_W-1:0] rd_t;
    assign rd_t = r_half ? rd_b : rd_a;

    always_ff @(posedge i_clk) begin
        if (accept && fits({1'b0, r_count} + 1'b1)) begin
            r_items[r_count[IW-1:0]] <= i_item_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_limit <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_half <= n_half;  r_k <= n_k;  r_iidx <= n_iidx;  r_len <= n_len;
        r_x <= n_x;  r_y <= n_y;  r_o <= n_o;  r_ph <= n_ph;
        r_tx <= n_tx;  r_ty <= n_ty;  r_v <= n_v;
        r_na_len <= n_na_len;  r_na <= n_na;
        r_i <= n_i;  r_lo <= n_lo;  r_hi <= n_hi;  r_mid <= n_mid;
        r_s <= n_s;  r_best <= n_best;
    end

    // next state and datapath
    always_comb begin
        logic [BEST_W-1:0] tot;
        logic              take_x;
        logic [SUM_W-1:0]  yv;
        n_state = r_state;
        n_count = r_count;  n_ovf = r_ovf;
        n_half = r_half;  n_k = r_k;  n_iidx = r_iidx;  n_len = r_len;
        n_x = r_x;  n_y = r_y;  n_o = r_o;  n_ph = r_ph;
        n_tx = r_tx;  n_ty = r_ty;  n_v = r_v;
        n_na_len = r_na_len;  n_na = r_na;
        n_i = r_i;  n_lo = r_lo;  n_hi = r_hi;  n_mid = r_mid;
        n_s = r_s;  n_best = r_best;
        tot = '0;
        yv = r_ty + SUM_W'(r_v);
        take_x = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (fits({1'b0, r_count} + 1'b1)) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_is_last) begin
                        n_na   = n_count >> 1;
                        n_half = 1'b0;
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                // table holds {0}
                n_len  = LW'(1);
                n_k    = r_half ? (r_count - r_na) : r_na;
                n_iidx = r_half ? r_na[IW-1:0] : '0;
                n_state = ST_GEN_RD;
            end
            ST_GEN_RD: begin
                if (r_k == '0) begin
                    if (!r_half) begin
                        n_na_len = r_len;
                        n_half = 1'b1;
                        n_state = ST_INIT;
                    end else begin
                        n_i = '0;
                        n_best = '0;
                        n_ph = '0;
                        n_state = ST_SRCH_A;
                    end
                end else begin
                    n_v = SUM_W'(r_items[r_iidx]);
                    n_x = '0;  n_y = '0;  n_o = '0;  n_ph = '0;
                    n_state = ST_GEN_MERGE;
                end
            end
            ST_GEN_MERGE: begin
                // phase 0: request x, 1: request y, 2: data of y ready
                case (r_ph)
                    2'd0: n_ph = 2'd1;
                    2'd1: begin
                        n_tx = rd_t;
                        n_ph = 2'd2;
                    end
                    default: begin
                        n_ty = rd_t;
                        yv = rd_t + r_v;
                        take_x = (r_x < r_len) &&
                                 ((r_y >= r_len) || (r_tx <= yv));
                        if (take_x) begin
                            n_x = r_x + 1'b1;
                        end else begin
                            n_y = r_y + 1'b1;
                        end
                        n_o = r_o + 1'b1;
                        n_ph = 2'd0;
                        if (r_o + 1'b1 == (r_len << 1)) begin
                            n_o = '0;
                            n_state = ST_GEN_COPY;
                        end
                    end
                endcase
            end
            ST_GEN_COPY: begin
                // phase 0: request buf o, 1: write table o
                case (r_ph)
                    2'd0: n_ph = 2'd1;
                    default: begin
                        n_ph = 2'd0;
                        n_o = r_o + 1'b1;
                        if (r_o + 1'b1 == (r_len << 1)) begin
                            n_len = r_len << 1;
                            n_k = r_k - 1'b1;
                            n_iidx = r_iidx + 1'b1;
                            n_state = ST_GEN_RD;
                        end
                    end
                endcase
            end
            ST_SRCH_A: begin
                // phase 0: request a[i], 1: data
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    n_ph = 2'd0;
                    n_s = rd_a;
                    if (rd_a > r_limit) begin
                        n_state = ST_DONE;
                    end else begin
                        n_lo = '0;
                        n_hi = r_len - 1'b1;
                        n_state = ST_SRCH_B;
                    end
                end
            end
            ST_SRCH_B: begin
                if (r_lo < r_hi) begin
                    n_mid = r_lo + ((r_hi - r_lo + 1'b1) >> 1);
                    n_ph = 2'd0;
                    n_state = ST_SRCH_CMP;
                end else begin
                    // lo settled: fetch b[lo]
                    n_mid = r_lo;
                    n_ph = 2'd2;
                    n_state = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                case (r_ph)
                    2'd0: n_ph = 2'd1;
                    2'd1: begin
                        n_ph = 2'd0;
                        if (rd_b <= r_limit - r_s) begin
                            n_lo = r_mid;
                        end else begin
                            n_hi = r_mid - 1'b1;
                        end
                        n_state = ST_SRCH_B;
                    end
                    2'd2: n_ph = 2'd3;
                    default: begin
                        n_ph = 2'd0;
                        tot = BEST_W'(r_s) + BEST_W'(rd_b);
                        if (tot > r_best) begin
                            n_best = tot;
                        end
                        n_i = r_i + 1'b1;
                        if (r_i + 1'b1 == r_na_len) begin
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_SRCH_A;
                        end
                    end
                endcase
            end
            ST_DONE: begin
                n_count = '0;
                n_ovf = 1'b0;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory port and output control
    always_comb begin
        logic [SUM_W-1:0] wv;
        we_a = 1'b0;  we_b = 1'b0;  we_m = 1'b0;
        wa_a = '0;  wa_b = '0;  wa_m = '0;
        wd_a = '0;  wd_b = '0;  wd_m = '0;
        ra_a = '0;  ra_b = '0;  ra_m = '0;
        wv = '0;
        o_busy = (r_state != ST_IDLE);
        o_done = (r_state == ST_DONE);
        o_best_sum = r_best;
        o_overflowed = r_ovf;
        case (r_state)
            ST_INIT: begin
                we_a = !r_half;
                we_b = r_half;
            end
            ST_GEN_MERGE: begin
                ra_a = (r_ph == 2'd0) ? r_x[AW-1:0] : r_y[AW-1:0];
                ra_b = ra_a;
                if (r_ph == 2'd2) begin
                    wv = ((r_x < r_len) &&
                          ((r_y >= r_len) || (r_tx <= rd_t + r_v))) ?
                         r_tx : (rd_t + r_v);
                    we_m = 1'b1;
                    wa_m = r_o[AW-1:0];
                    wd_m = wv;
                end
            end
            ST_GEN_COPY: begin
                ra_m = r_o[AW-1:0];
                if (r_ph != 2'd0) begin
                    we_a = !r_half;
                    we_b = r_half;
                    wa_a = r_o[AW-1:0];
                    wa_b = r_o[AW-1:0];
                    wd_a = rd_m;
                    wd_b = rd_m;
                end
            end
            ST_SRCH_A: ra_a = r_i[AW-1:0];
            ST_SRCH_CMP: ra_b = r_mid[AW-1:0];
            default: ;
        endcase
    end

    `MSS_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, o_busy)
    `MSS_ASSERT_NEXT(a_done_clear, i_clk, i_rst_n, o_done, (r_count == '0) && !r_ovf)
    `MSS_ASSERT_IMPL(a_best_lim, i_clk, i_rst_n, o_done, (o_best_sum <= BEST_W'(r_limit)))
    `MSS_ASSERT_IMPL(a_bounds, i_clk, i_rst_n, r_state == ST_SRCH_CMP, r_lo <= r_mid)
endmodule
`default_nettype wire

[tb/testbench.sv]
// testbench, meet-in-the-middle subset sum block: directed and random sets, scoreboard check
`default_nettype none

// tracks the loaded set, predicts the best sum and checks each result word
class subset_sum_board;
    bit [35:0] limit;
    bit [30:0] kept[$];
    bit        dropped;
    bit [36:0] exp_best[$];
    bit        exp_ovf[$];
    int        errors;

    function new();
        limit   = '0;
        dropped = 1'b0;
        errors  = 0;
    endfunction

    // all subset sums of kept[lo .. lo+cnt)
    function automatic void list_sums(int lo, int cnt, ref bit [35:0] sums[$]);
        int n;
        sums = {};
        sums.push_back('0);
        for (int k = 0; k < cnt; k++) begin
            n = sums.size();
            for (int j = 0; j < n; j++) sums.push_back(sums[j] + kept[lo + k]);
        end
    endfunction

    function automatic bit [36:0] best_pair_sum();
        bit [35:0] a_sums[$];
        bit [35:0] b_sums[$];
        bit [36:0] best;
        bit [36:0] total;
        int        na;
        int        lo;
        int        hi;
        int        mid;
        na = kept.size() / 2;
        list_sums(0, na, a_sums);
        list_sums(na, kept.size() - na, b_sums);
        b_sums.sort();
        best = '0;
        foreach (a_sums[i]) begin
            if (a_sums[i] > limit) continue;
            // largest second-half sum not above what is left of the limit
            lo = 0;
            hi = b_sums.size() - 1;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                if (b_sums[mid] <= limit - a_sums[i]) lo = mid;
                else hi = mid - 1;
            end
            total = a_sums[i] + b_sums[lo];
            if (total > best) best = total;
        end
        return best;
    endfunction

    function void note_word(bit [30:0] value, bit last);
        if (kept.size() < 32) kept.push_back(value);
        else dropped = 1'b1;
        if (last) begin
            exp_best.push_back(best_pair_sum());
            exp_ovf.push_back(dropped);
            kept    = {};
            dropped = 1'b0;
        end
    endfunction

    function void check(bit [36:0] best, bit ovf);
        bit [36:0] eb;
        bit        eo;
        if (exp_best.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word: best %0d ovf %0d", best, ovf);
            return;
        end
        eb = exp_best.pop_front();
        eo = exp_ovf.pop_front();
        if (best !== eb || ovf !== eo) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: best exp %0d got %0d, ovf exp %0d got %0d",
                         eb, best, eo, ovf);
        end
    endfunction

    function int pending();
        return exp_best.size();
    endfunction
endclass

module testbench;
    import mss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              o_busy;
    logic [VAL_W-1:0]  i_item_value = '0;
    logic              i_is_last = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [SUM_W-1:0]  i_cfg_data = '0;
    logic              o_done;
    logic [BEST_W-1:0] o_best_sum;
    logic              o_overflowed;

    subset_sum_board board = new();

    max_subset_sum_under_limit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item_value(i_item_value),
        .i_is_last   (i_is_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_best_sum  (o_best_sum),
        .o_overflowed(o_overflowed)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result words cannot be held off, so every done cycle is checked
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) board.check(o_best_sum, o_overflowed);
    end

    // one word, with random idle cycles ahead of it; called just after an edge,
    // so the next word is driven at the very edge that takes this one
    task automatic send_word(bit [30:0] value, bit last, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_item_value <= value;
        i_is_last    <= last;
        // taken at the first edge where busy is low
        do @(posedge i_clk); while (o_busy);
        board.note_word(value, last);
    endtask

    // limit is only changed with nothing in flight and the sequencer idle
    task automatic write_limit(bit [35:0] value);
        i_start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.limit = value;
    endtask

    function automatic bit [30:0] pick_value(int mode);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return 31'($urandom_range(0, 600));
            default: return (mode == 1) ? 31'($urandom_range(0, 600)) : 31'($urandom);
        endcase
    endfunction

    task automatic send_set(int n, int idle_pct, int mode);
        for (int k = 0; k < n; k++) send_word(pick_value(mode), k == n - 1, idle_pct);
    endtask

    initial begin
        int idle_pct;
        int sent;
        int n;
        int mode;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes of value and limit, single items, even and odd sets
        write_limit('0);
        send_word('0, 1'b1, 0);
        send_word('1, 1'b1, 0);
        send_word(31'd5, 1'b0, 0);
        send_word(31'd0, 1'b1, 0);
        write_limit('1);
        send_word('1, 1'b1, 0);
        for (int k = 0; k < 8; k++) send_word('1, k == 7, 0);
        send_word(31'd3, 1'b0, 0);
        send_word(31'd9, 1'b0, 0);
        send_word('1, 1'b1, 0);
        write_limit(36'd12);
        send_word(31'd5, 1'b0, 0);
        send_word(31'd8, 1'b0, 0);
        send_word(31'd7, 1'b0, 0);
        send_word(31'd13, 1'b1, 0);
        write_limit(36'd4294967294);
        send_word('1, 1'b0, 0);
        send_word('1, 1'b0, 0);
        send_word(31'd1, 1'b1, 0);

        // random phases: sender idling varies, the limit changes per phase
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 65;
                2: idle_pct = 0;
                default: idle_pct = 34;
            endcase
            mode = ph % 3;
            case (ph)
                0: write_limit('1);
                1: write_limit(36'($urandom_range(0, 2000)));
                2: write_limit(36'({$urandom, $urandom}) & 36'h3_FFFF_FFFF);
                3: write_limit('0);
                4: write_limit(36'({$urandom, $urandom}));
                5: write_limit(36'($urandom_range(0, 3000)));
                6: write_limit({4'h0, $urandom});
                default: write_limit(36'({$urandom, $urandom}) & 36'h1_FFFF_FFFF);
            endcase
            // capacity case once: full set of 32 kept, two more dropped, last dropped
            if (ph == 2) send_set(34, idle_pct, mode);
            sent = 0;
            while (sent < 85) begin
                n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 12))
                                                : int'($urandom_range(1, 7));
                send_set(n, idle_pct, mode);
                sent += n;
            end
        end

        i_start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // generous wall: one full-capacity set plus many small ones
    initial begin
        #1000000000;
        $display("simulation failed");
        $finish;
    end
endmodule

`default_nettype wire
